// ===== rtl/core/pfcr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfcr_pkg
// Shared types and constants of the renormalizing FIR convolver.
// ----------------------------------------------------------------------------
package pfcr_pkg;

    localparam int MAX_TAPS    = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 16;
    localparam int TAP_AW      = $clog2(MAX_TAPS);
    localparam int CNT_W       = $clog2(2 * MAX_TAPS);
    localparam int RES_W       = 24;
    localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W       = PROD_W + TAP_AW + 1;
    localparam int NORM_W      = COEF_BITS + TAP_AW + 1;
    localparam int MAG_W       = ACC_W + 1;
    localparam int QDEPTH      = 4;
    localparam int QAW         = $clog2(QDEPTH);

    localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(2 * MAX_TAPS - 1);

    localparam logic OP_TAP    = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [1:0] REG_PHASE = 2'd0;
    localparam logic [1:0] REG_RENRM = 2'd1;
    localparam logic [1:0] REG_TAPS  = 2'd2;

    // One result job handed from the front to the back.
    typedef struct packed {
        logic [TAP_AW-1:0] n;     // lag of the oldest sample within history (clamped)
        logic [TAP_AW-1:0] e;     // extension past newest sample
        logic              last;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DIV,
        ST_ROUND,
        ST_OUT
    } t_back_state;

endpackage

// ===== rtl/core/phased_fir_convolve_renorm_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phased_fir_convolve_renorm_top
// FIR convolver with edge renormalization and phase lookahead.
// ----------------------------------------------------------------------------
// Each result is computed by serial multiply-accumulate (one tap per cycle
// through the tap and sample RAM read ports), then by bit-serial division,
// rounding and saturation. A sample is accepted once every result of the
// previous item has left the output register; the last sample releases up to
// phase_offset+1 results queued back to back. No clearing pass after reset.
module phased_fir_convolve_renorm_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: [5:0] tap_index, [21:6] tap_value, [37:22] sample
    input  wire [39:0]  s_axis_tdata,
    // tuser: [0] operation
    input  wire         s_axis_tuser,
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // tdata: [23:0] result
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast,
    // tuser: [0] norm_zero, [1] saturated
    output logic [1:0]  m_axis_tuser,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [3:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pfcr_pkg::*;

    logic [5:0] r_phase;
    logic       r_renorm;
    logic [6:0] r_taps;

    logic tap_we, smp_we, job_valid, job_take, back_idle;
    logic [TAP_AW-1:0] tap_waddr, smp_waddr, tap_raddr, smp_raddr, head;
    logic [COEF_BITS-1:0]   tap_wdata, tap_rdata;
    logic [SAMPLE_BITS-1:0] smp_wdata, smp_rdata;
    t_job job;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_renorm <= 1'b1;
            r_taps   <= 7'd64;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_PHASE: r_phase  <= pwdata[5:0];
                REG_RENRM: r_renorm <= pwdata[0];
                REG_TAPS:  r_taps   <= pwdata[6:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_PHASE: prdata = {26'd0, r_phase};
            REG_RENRM: prdata = {31'd0, r_renorm};
            REG_TAPS:  prdata = {25'd0, r_taps};
            default:   prdata = '0;
        endcase
    end

    pfcr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_operation  (s_axis_tuser),
        .i_tap_index  (s_axis_tdata[5:0]),
        .i_tap_value  (s_axis_tdata[21:6]),
        .i_sample     (s_axis_tdata[37:22]),
        .i_last_sample(s_axis_tlast),
        .i_phase      (r_phase),
        .o_tap_we     (tap_we),
        .o_tap_addr   (tap_waddr),
        .o_tap_data   (tap_wdata),
        .o_smp_we     (smp_we),
        .o_smp_addr   (smp_waddr),
        .o_smp_data   (smp_wdata),
        .o_head       (head),
        .o_job_valid  (job_valid),
        .o_job        (job),
        .i_job_take   (job_take),
        .i_back_idle  (back_idle)
    );

    pfcr_ram #(.WIDTH(COEF_BITS), .DEPTH(MAX_TAPS)) u_tap_ram (
        .i_clk  (i_clk),
        .i_we   (tap_we),
        .i_waddr(tap_waddr),
        .i_wdata(tap_wdata),
        .i_raddr(tap_raddr),
        .o_rdata(tap_rdata)
    );

    pfcr_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_smp_ram (
        .i_clk  (i_clk),
        .i_we   (smp_we),
        .i_waddr(smp_waddr),
        .i_wdata(smp_wdata),
        .i_raddr(smp_raddr),
        .o_rdata(smp_rdata)
    );

    pfcr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_take  (job_take),
        .o_idle      (back_idle),
        .i_renorm    (r_renorm),
        .i_taps_used (r_taps),
        .i_head      (head),
        .o_tap_raddr (tap_raddr),
        .i_tap_rdata (tap_rdata),
        .o_smp_raddr (smp_raddr),
        .i_smp_rdata (smp_rdata),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_result    (m_axis_tdata),
        .o_last      (m_axis_tlast),
        .o_norm_zero (m_axis_tuser[0]),
        .o_saturated (m_axis_tuser[1])
    );

endmodule
`default_nettype wire

// ===== rtl/core/pfcr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfcr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfcr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/pfcr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfcr_front
// Accepts items, writes taps and samples, and queues one job per result.
// ----------------------------------------------------------------------------
module pfcr_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire                          i_operation,
    input  wire [pfcr_pkg::TAP_AW-1:0]   i_tap_index,
    input  wire [pfcr_pkg::COEF_BITS-1:0]   i_tap_value,
    input  wire [pfcr_pkg::SAMPLE_BITS-1:0] i_sample,
    input  wire                          i_last_sample,
    input  wire [5:0]                    i_phase,
    output logic                         o_tap_we,
    output logic [pfcr_pkg::TAP_AW-1:0]  o_tap_addr,
    output logic [pfcr_pkg::COEF_BITS-1:0] o_tap_data,
    output logic                         o_smp_we,
    output logic [pfcr_pkg::TAP_AW-1:0]  o_smp_addr,
    output logic [pfcr_pkg::SAMPLE_BITS-1:0] o_smp_data,
    output logic [pfcr_pkg::TAP_AW-1:0]  o_head,
    output logic                         o_job_valid,
    output pfcr_pkg::t_job               o_job,
    input  wire                          i_job_take,
    input  wire                          i_back_idle
);
    import pfcr_pkg::*;

    // Samples live in a circular buffer; r_head points at the newest one.
    logic [TAP_AW-1:0] r_head, n_head;
    logic [CNT_W-1:0]  r_count;
    // Pending end-of-series emission: a counter over extensions.
    logic              r_emit;
    logic [TAP_AW-1:0] r_e, r_ph, r_n;
    logic              r_hold;   // history write in flight; keep back from reading old head

    t_job             r_q [QDEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QAW:0]     r_fill;

    logic             acc, push, qfull;
    t_job             push_job;
    logic [TAP_AW-1:0] ph_c;
    logic [CNT_W-1:0]  cnt_nx;
    logic [CNT_W-1:0]  n_full;

    assign ph_c   = i_phase[TAP_AW-1:0];
    assign qfull  = (r_fill == (QAW+1)'(QDEPTH));
    // One item at a time: the next sample waits until all jobs of this one are done.
    assign o_ready = !r_emit && (r_fill == '0) && i_back_idle && !r_hold;
    assign acc    = i_valid && o_ready;
    assign n_head = r_head + TAP_AW'(1);

    assign o_tap_we   = acc && (i_operation == OP_TAP);
    assign o_tap_addr = i_tap_index;
    assign o_tap_data = i_tap_value;
    assign o_smp_we   = acc && (i_operation == OP_SAMPLE);
    assign o_smp_addr = n_head;
    assign o_smp_data = i_sample;
    assign o_head     = r_head;

    assign cnt_nx = (r_count < COUNT_CAP) ? r_count + CNT_W'(1) : r_count;
    assign n_full = cnt_nx - CNT_W'(1);

    always_comb begin
        push     = 1'b0;
        push_job = '0;
        if (r_emit && !qfull) begin
            push       = 1'b1;
            push_job.n = r_n;
            push_job.e = r_e;
            push_job.last = (r_e == r_ph);
        end else if (o_smp_we && !i_last_sample && (n_full >= CNT_W'(ph_c))) begin
            push       = 1'b1;
            push_job.n = (n_full >= CNT_W'(MAX_TAPS)) ? TAP_AW'(MAX_TAPS-1)
                                                       : n_full[TAP_AW-1:0];
            push_job.e = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_emit  <= 1'b0;
            r_hold  <= 1'b0;
            r_wp    <= '0;
            r_rp    <= '0;
            r_fill  <= '0;
        end else begin
            r_hold <= o_smp_we;
            if (o_smp_we) begin
                r_head <= n_head;
                if (i_last_sample) begin
                    r_count <= '0;
                    r_emit  <= 1'b1;
                    r_ph    <= ph_c;
                    r_n     <= (n_full >= CNT_W'(MAX_TAPS)) ? TAP_AW'(MAX_TAPS-1)
                                                            : n_full[TAP_AW-1:0];
                    // skip extensions with n + e < ph
                    r_e     <= (n_full >= CNT_W'(ph_c)) ? '0
                                                        : TAP_AW'(CNT_W'(ph_c) - n_full);
                end else begin
                    r_count <= cnt_nx;
                end
            end else if (r_emit && !qfull) begin
                if (r_e == r_ph) begin
                    r_emit <= 1'b0;
                end else begin
                    r_e <= r_e + TAP_AW'(1);
                end
            end
            if (push) begin
                r_q[r_wp] <= push_job;
                r_wp      <= r_wp + QAW'(1);
            end
            if (i_job_take) begin
                r_rp <= r_rp + QAW'(1);
            end
            r_fill <= r_fill + (QAW+1)'(push) - (QAW+1)'(i_job_take);
        end
    end

    assign o_job_valid = (r_fill != '0) && !r_hold;
    assign o_job       = r_q[r_rp];

endmodule
`default_nettype wire

// ===== rtl/core/pfcr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfcr_back
// Runs one job: tap-serial multiply-accumulate, serial division, round and
// saturate, then holds the result in an output register.
// ----------------------------------------------------------------------------
module pfcr_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_job_valid,
    input  pfcr_pkg::t_job               i_job,
    output logic                         o_job_take,
    output logic                         o_idle,
    input  wire                          i_renorm,
    input  wire [6:0]                    i_taps_used,
    input  wire [pfcr_pkg::TAP_AW-1:0]   i_head,
    output logic [pfcr_pkg::TAP_AW-1:0]  o_tap_raddr,
    input  wire [pfcr_pkg::COEF_BITS-1:0] i_tap_rdata,
    output logic [pfcr_pkg::TAP_AW-1:0]  o_smp_raddr,
    input  wire [pfcr_pkg::SAMPLE_BITS-1:0] i_smp_rdata,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [pfcr_pkg::RES_W-1:0]   o_result,
    output logic                         o_last,
    output logic                         o_norm_zero,
    output logic                         o_saturated
);
    import pfcr_pkg::*;

    localparam int DCW = $clog2(MAG_W + 1);

    t_back_state r_state, n_state;
    t_job        r_job;
    logic [TAP_AW:0]   r_i;        // tap index issued
    logic              r_rv;       // RAM read data valid
    logic              r_rok;      // the issued read counts
    logic              r_pv;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [COEF_BITS-1:0] r_ptap;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [NORM_W-1:0] r_norm;
    logic [MAG_W-1:0]  r_rem, r_quo, r_den;
    logic              r_neg;
    logic [DCW-1:0]    r_dc;
    logic [MAG_W-1:0]  r_mag;
    logic [TAP_AW:0]   k;
    logic [TAP_AW:0]   d;
    logic              issue_ok;
    logic [MAG_W:0]    trial;
    logic [MAG_W-1:0]  rem_sh;
    logic [MAG_W-1:0]  qr;
    logic [MAG_W-1:0]  lim;
    logic              mac_done;

    assign k = (i_taps_used > 7'(MAX_TAPS)) ? (TAP_AW+1)'(MAX_TAPS)
                                            : (TAP_AW+1)'(i_taps_used);
    assign d = r_i - (TAP_AW+1)'(r_job.e);
    assign issue_ok = (r_i < k) && (d <= (TAP_AW+1)'(r_job.n));
    assign o_tap_raddr = r_i[TAP_AW-1:0];
    assign o_smp_raddr = i_head - d[TAP_AW-1:0];
    assign mac_done = (r_i >= k) && !r_rv && !r_pv;

    assign o_idle     = (r_state == ST_IDLE) && !o_valid;
    assign o_job_take = (r_state == ST_IDLE) && !o_valid && i_job_valid;

    assign rem_sh = {r_rem[MAG_W-2:0], r_mag[MAG_W-1]};
    assign trial  = {1'b0, rem_sh} - {1'b0, r_den};
    assign lim    = r_neg ? MAG_W'(24'd8388608) : MAG_W'(24'd8388607);
    // round half away: remainder*2 >= divisor
    assign qr     = ({r_rem, 1'b0} >= {1'b0, r_den}) ? r_quo + MAG_W'(1) : r_quo;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (o_job_take) n_state = ST_MAC;
            ST_MAC:   if (mac_done) n_state = ST_DIV;
            ST_DIV:   if (r_dc == '0) n_state = ST_ROUND;
            ST_ROUND: n_state = ST_OUT;
            ST_OUT:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            o_valid <= 1'b0;
            r_rv    <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_rv <= 1'b0;
                    r_pv <= 1'b0;
                    if (o_job_take) begin
                        r_job  <= i_job;
                        r_i    <= (TAP_AW+1)'(i_job.e);
                        r_acc  <= '0;
                        r_norm <= '0;
                    end
                end
                ST_MAC: begin
                    // issue read, then multiply, then accumulate
                    r_rv  <= r_i < k;
                    r_rok <= issue_ok;
                    if (r_i < k) begin
                        r_i <= r_i + (TAP_AW+1)'(1);
                    end
                    r_pv <= r_rv && r_rok;
                    if (r_rv && r_rok) begin
                        r_prod <= $signed(i_smp_rdata) * $signed(i_tap_rdata);
                        r_ptap <= $signed(i_tap_rdata);
                    end
                    if (r_pv) begin
                        r_acc  <= r_acc + ACC_W'(r_prod);
                        r_norm <= r_norm + NORM_W'(r_ptap);
                    end
                    if (mac_done) begin
                        r_mag <= r_acc[ACC_W-1] ? MAG_W'(-r_acc) : MAG_W'(r_acc);
                        r_rem <= '0;
                        r_quo <= '0;
                        r_dc  <= DCW'(MAG_W);
                        if (i_renorm) begin
                            r_den <= r_norm[NORM_W-1] ? MAG_W'(-r_norm) : MAG_W'(r_norm);
                            r_neg <= r_acc[ACC_W-1] ^ r_norm[NORM_W-1];
                        end else begin
                            r_den <= MAG_W'(1) << (COEF_BITS - 1);
                            r_neg <= r_acc[ACC_W-1];
                        end
                    end
                end
                ST_DIV: begin
                    if (r_dc != '0) begin
                        r_mag <= {r_mag[MAG_W-2:0], 1'b0};
                        if (!trial[MAG_W]) begin
                            r_rem <= trial[MAG_W-1:0];
                            r_quo <= {r_quo[MAG_W-2:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh;
                            r_quo <= {r_quo[MAG_W-2:0], 1'b0};
                        end
                        r_dc <= r_dc - DCW'(1);
                    end
                end
                ST_ROUND: begin
                    r_quo <= qr;
                end
                ST_OUT: begin
                    o_valid <= 1'b1;
                    o_last  <= r_job.last;
                    if (r_den == '0) begin
                        o_result    <= '0;
                        o_norm_zero <= 1'b1;
                        o_saturated <= 1'b0;
                    end else begin
                        o_norm_zero <= 1'b0;
                        if (r_quo > lim) begin
                            o_saturated <= 1'b1;
                            o_result    <= r_neg ? RES_W'(24'h800000) : RES_W'(24'h7FFFFF);
                        end else begin
                            o_saturated <= 1'b0;
                            o_result    <= r_neg ? RES_W'(-r_quo) : r_quo[RES_W-1:0];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire
